/* rtl/tsr_pkg.sv */
`default_nettype none

package tsr_pkg;

  // Video memory geometry.
  localparam int unsigned VRAM_DEPTH = 8192;
  localparam int unsigned VRAM_AW    = 13;
  // The background tile map starts at this video offset.
  localparam logic [VRAM_AW-1:0] MAP_BASE = 13'h1800;
  // Last video address, where the clearing sweep ends.
  localparam logic [VRAM_AW-1:0] VRAM_LAST = 13'h1FFF;

  // Register indexes of the configuration port.
  localparam logic CFG_SCROLL_Y = 1'b0;
  localparam logic CFG_SCROLL_X = 1'b1;

  // Item kinds carried in the input tuser.
  typedef enum logic [1:0] {
    MODE_VRAM   = 2'd0,
    MODE_OBJ    = 2'd1,
    MODE_RENDER = 2'd2
  } mode_e;

  // Source of the video memory read address.
  typedef enum logic [2:0] {
    VSEL_MAP    = 3'd0,
    VSEL_BG_LO  = 3'd1,
    VSEL_BG_HI  = 3'd2,
    VSEL_OBJ_LO = 3'd3,
    VSEL_OBJ_HI = 3'd4
  } vsel_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR   = 4'd0,
    ST_IDLE    = 4'd1,
    ST_BG_MAP  = 4'd2,
    ST_BG_LO   = 4'd3,
    ST_BG_HI   = 4'd4,
    ST_BG_COL  = 4'd5,
    ST_OBJ_RD  = 4'd6,
    ST_OBJ_CHK = 4'd7,
    ST_OBJ_LO  = 4'd8,
    ST_OBJ_HI  = 4'd9,
    ST_EMIT    = 4'd10
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    vsel_e vsel;
    logic  clr_step;
    logic  take_item;
    logic  cap_bg_tile;
    logic  cap_obj;
    logic  cap_lo;
    logic  bg_color;
    logic  obj_color;
    logic  idx_inc;
    logic  emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic covered;
    logic last_obj;
    logic on_line;
    logic out_free;
  } status_t;

  // Two-bit color of one tile pixel; the leftmost pixel sits in bit 7.
  function automatic logic [1:0] pixel_color(logic [7:0] lo, logic [7:0] hi,
                                             logic [2:0] col);
    logic [2:0] b;
    b = 3'd7 - col;
    return {hi[b], lo[b]};
  endfunction

endpackage

`default_nettype wire

/* rtl/tsr_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module tsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/tsr_ctrl.sv */
`default_nettype none

// Sequencer for the clearing sweep, write items and the per-pixel render walk.
module tsr_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_tvalid_i,
  input  wire logic [1:0]       mode_i,
  output logic                  s_tready_o,
  input  wire tsr_pkg::status_t status_i,
  output tsr_pkg::cmd_t         cmd_o
);

  tsr_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.vsel = tsr_pkg::VSEL_MAP;
    case (state_q)
      tsr_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) begin
          state_d = tsr_pkg::ST_IDLE;
        end
      end
      tsr_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.take_item = 1'b1;
          if (tsr_pkg::mode_e'(mode_i) == tsr_pkg::MODE_RENDER) begin
            state_d = tsr_pkg::ST_BG_MAP;
          end
        end
      end
      tsr_pkg::ST_BG_MAP: begin
        cmd_o.vsel = tsr_pkg::VSEL_MAP;
        state_d    = tsr_pkg::ST_BG_LO;
      end
      tsr_pkg::ST_BG_LO: begin
        cmd_o.vsel        = tsr_pkg::VSEL_BG_LO;
        cmd_o.cap_bg_tile = 1'b1;
        state_d           = tsr_pkg::ST_BG_HI;
      end
      tsr_pkg::ST_BG_HI: begin
        cmd_o.vsel   = tsr_pkg::VSEL_BG_HI;
        cmd_o.cap_lo = 1'b1;
        state_d      = tsr_pkg::ST_BG_COL;
      end
      tsr_pkg::ST_BG_COL: begin
        cmd_o.bg_color = 1'b1;
        state_d = status_i.on_line ? tsr_pkg::ST_OBJ_RD : tsr_pkg::ST_EMIT;
      end
      tsr_pkg::ST_OBJ_RD: begin
        state_d = tsr_pkg::ST_OBJ_CHK;
      end
      tsr_pkg::ST_OBJ_CHK: begin
        if (status_i.covered) begin
          cmd_o.vsel    = tsr_pkg::VSEL_OBJ_LO;
          cmd_o.cap_obj = 1'b1;
          state_d       = tsr_pkg::ST_OBJ_LO;
        end else if (status_i.last_obj) begin
          state_d = tsr_pkg::ST_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = tsr_pkg::ST_OBJ_RD;
        end
      end
      tsr_pkg::ST_OBJ_LO: begin
        cmd_o.vsel   = tsr_pkg::VSEL_OBJ_HI;
        cmd_o.cap_lo = 1'b1;
        state_d      = tsr_pkg::ST_OBJ_HI;
      end
      tsr_pkg::ST_OBJ_HI: begin
        cmd_o.obj_color = 1'b1;
        if (status_i.last_obj) begin
          state_d = tsr_pkg::ST_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = tsr_pkg::ST_OBJ_RD;
        end
      end
      tsr_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = tsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsr_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  // No item is taken while the memories are being cleared.
  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsr_pkg::ST_CLEAR) |-> !s_tready_o)
    else $error("item accepted during clearing sweep");

  // A render item always starts the background fetch on the next cycle.
  a_render_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take_item && tsr_pkg::mode_e'(mode_i) == tsr_pkg::MODE_RENDER)
      |=> (state_q == tsr_pkg::ST_BG_MAP))
    else $error("render item did not start background fetch");

  // The object walk only advances after an object was examined.
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.idx_inc |-> (state_q == tsr_pkg::ST_OBJ_CHK || state_q == tsr_pkg::ST_OBJ_HI))
    else $error("object index stepped outside the object walk");
`endif

endmodule

`default_nettype wire

/* rtl/tsr_datapath.sv */
`default_nettype none

// Memories, scroll registers, address generation, object test and result register.
module tsr_datapath #(
  parameter int unsigned OBJECT_COUNT = 40,
  parameter int unsigned LINE_WIDTH   = 160
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  input  wire logic [1:0]    mode_i,
  input  wire logic [12:0]   address_i,
  input  wire logic [7:0]    data_i,
  input  wire logic [7:0]    line_i,
  input  wire logic [7:0]    column_i,
  input  wire tsr_pkg::cmd_t cmd_i,
  output tsr_pkg::status_t   status_o,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i,
  output logic [1:0]         color_o,
  output logic               from_object_o
);

  localparam int unsigned OIW = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;
  localparam int unsigned OBJ_BYTES = OBJECT_COUNT * 4;

  localparam int unsigned VAW = tsr_pkg::VRAM_AW;

  logic [7:0]     scroll_y_q, scroll_x_q;
  logic [7:0]     line_q, column_q;
  logic [7:0]     tile_q, lo_q;
  logic [2:0]     row_q, col_q;
  logic [1:0]     color_q;
  logic           hit_q;
  logic [OIW-1:0] idx_q;
  logic [VAW-1:0] clr_q;
  logic           m_valid_q;
  logic [1:0]     out_color_q;
  logic           out_obj_q;

  logic [7:0]     bg_y, bg_x;
  logic           vram_we;
  logic [VAW-1:0] vram_waddr, vram_raddr;
  logic [7:0]     vram_wdata, vram_rd;
  logic           obj_wr_ok, obj_clr;
  logic [OIW-1:0] obj_waddr;
  logic [7:0]     obj_wdata;
  logic [2:0]     obj_we;
  logic [7:0]     obj_y_rd, obj_x_rd, obj_tile_rd;
  logic [9:0]     dy, dx;
  logic [1:0]     obj_pix;

  // Scroll registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_y_q <= '0;
      scroll_x_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tsr_pkg::CFG_SCROLL_Y) begin
        scroll_y_q <= cfg_data_i;
      end else begin
        scroll_x_q <= cfg_data_i;
      end
    end
  end

  // Background coordinates wrap at 256.
  assign bg_y = line_q + scroll_y_q;
  assign bg_x = column_q + scroll_x_q;

  // Video memory write: clearing sweep or a video write item.
  assign vram_we    = cmd_i.clr_step ||
                      (cmd_i.take_item && tsr_pkg::mode_e'(mode_i) == tsr_pkg::MODE_VRAM);
  assign vram_waddr = cmd_i.clr_step ? clr_q : address_i;
  assign vram_wdata = cmd_i.clr_step ? 8'h00 : data_i;

  // Video memory read address.
  always_comb begin
    case (cmd_i.vsel)
      tsr_pkg::VSEL_MAP:    vram_raddr = tsr_pkg::MAP_BASE | {3'b000, bg_y[7:3], bg_x[7:3]};
      tsr_pkg::VSEL_BG_LO:  vram_raddr = {1'b0, vram_rd, bg_y[2:0], 1'b0};
      tsr_pkg::VSEL_BG_HI:  vram_raddr = {1'b0, tile_q, bg_y[2:0], 1'b1};
      tsr_pkg::VSEL_OBJ_LO: vram_raddr = {1'b0, obj_tile_rd, dy[2:0], 1'b0};
      tsr_pkg::VSEL_OBJ_HI: vram_raddr = {1'b0, tile_q, row_q, 1'b1};
      default:              vram_raddr = tsr_pkg::MAP_BASE;
    endcase
  end

  tsr_ram #(
    .WIDTH (8),
    .DEPTH (tsr_pkg::VRAM_DEPTH)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rd)
  );

  // Object table: one RAM per used byte of an entry (Y, X, tile).
  assign obj_clr   = cmd_i.clr_step && (clr_q < VAW'(OBJECT_COUNT));
  assign obj_wr_ok = cmd_i.take_item && tsr_pkg::mode_e'(mode_i) == tsr_pkg::MODE_OBJ &&
                     (address_i < VAW'(OBJ_BYTES));
  assign obj_waddr = cmd_i.clr_step ? clr_q[OIW-1:0] : address_i[2 +: OIW];
  assign obj_wdata = cmd_i.clr_step ? 8'h00 : data_i;
  assign obj_we[0] = obj_clr || (obj_wr_ok && address_i[1:0] == 2'd0);
  assign obj_we[1] = obj_clr || (obj_wr_ok && address_i[1:0] == 2'd1);
  assign obj_we[2] = obj_clr || (obj_wr_ok && address_i[1:0] == 2'd2);

  tsr_ram #(.WIDTH(8), .DEPTH(OBJECT_COUNT)) u_obj_y (
    .clk_i (clk_i), .we_i (obj_we[0]), .waddr_i (obj_waddr), .wdata_i (obj_wdata),
    .raddr_i (idx_q), .rdata_o (obj_y_rd)
  );

  tsr_ram #(.WIDTH(8), .DEPTH(OBJECT_COUNT)) u_obj_x (
    .clk_i (clk_i), .we_i (obj_we[1]), .waddr_i (obj_waddr), .wdata_i (obj_wdata),
    .raddr_i (idx_q), .rdata_o (obj_x_rd)
  );

  tsr_ram #(.WIDTH(8), .DEPTH(OBJECT_COUNT)) u_obj_tile (
    .clk_i (clk_i), .we_i (obj_we[2]), .waddr_i (obj_waddr), .wdata_i (obj_wdata),
    .raddr_i (idx_q), .rdata_o (obj_tile_rd)
  );

  // Offset of the pixel inside the object; covered when both lie in 0..7.
  assign dy = {2'b00, line_q} + 10'd16 - {2'b00, obj_y_rd};
  assign dx = {2'b00, column_q} + 10'd8 - {2'b00, obj_x_rd};

  assign obj_pix = tsr_pkg::pixel_color(lo_q, vram_rd, col_q);

  // Status toward the controller.
  assign status_o.clr_done = (clr_q == tsr_pkg::VRAM_LAST);
  assign status_o.covered  = (dy[9:3] == 7'd0) && (dx[9:3] == 7'd0);
  assign status_o.last_obj = (idx_q == OIW'(OBJECT_COUNT - 1));
  assign status_o.on_line  = ({1'b0, column_q} < 9'(LINE_WIDTH));
  assign status_o.out_free = !m_valid_q || m_tready_i;

  // Control counters: clearing address, object index and object hit flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      idx_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.bg_color) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.obj_color && obj_pix != 2'd0) begin
        hit_q <= 1'b1;
      end
    end
  end

  // Working registers of one render item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      line_q   <= line_i;
      column_q <= column_i;
    end
    if (cmd_i.cap_bg_tile) begin
      tile_q <= vram_rd;
    end
    if (cmd_i.cap_obj) begin
      tile_q <= obj_tile_rd;
      row_q  <= dy[2:0];
      col_q  <= dx[2:0];
    end
    if (cmd_i.cap_lo) begin
      lo_q <= vram_rd;
    end
    if (cmd_i.bg_color) begin
      color_q <= tsr_pkg::pixel_color(lo_q, vram_rd, bg_x[2:0]);
    end
    if (cmd_i.obj_color && obj_pix != 2'd0) begin
      color_q <= obj_pix;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_color_q <= color_q;
      out_obj_q   <= hit_q;
    end
  end

  assign m_tvalid_o    = m_valid_q;
  assign color_o       = out_color_q;
  assign from_object_o = out_obj_q;

`ifndef ASSERT_OFF
  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!m_valid_q || m_tready_i))
    else $error("result overwrote a word not yet taken");

  // An object pixel can only win on a column that lies on the line.
  a_hit_on_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && hit_q) |-> status_o.on_line)
    else $error("object pixel reported off the line");

  // The object index never runs past the last table entry.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= OIW'(OBJECT_COUNT - 1))
    else $error("object index out of range");
`endif

endmodule

`default_nettype wire

/* rtl/tile_sprite_pixel_renderer.sv */
// Write items (video or object table byte) are accepted in idle and written at once, one a cycle.
// A render item fetches the map entry, then both bytes of the background tile row; for a column
// on the line it then reads every object entry and, for each covering one, both bytes of its tile
// row. The map and tile fetches all share the one video memory port.
// The next item is taken in the cycle after the word is loaded; loading waits for a free output.
// Reset is asynchronous and active low; a clearing pass over all 8192 video addresses then zeros both memories.
`default_nettype none

module tile_sprite_pixel_renderer #(
  parameter int unsigned OBJECT_COUNT = 40,
  parameter int unsigned LINE_WIDTH   = 160
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // address[12:0], data[20:13], line[28:21],
                                          // column[36:29], zero fill[39:37]
  input  wire logic [1:0]  s_axis_tuser,  // mode[1:0]
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // color[1:0], zero fill[7:2]
  output logic             m_axis_tuser   // from_object[0]
);

  tsr_pkg::cmd_t    cmd;
  tsr_pkg::status_t status;
  logic [1:0]       color;

  tsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .mode_i     (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsr_datapath #(
    .OBJECT_COUNT (OBJECT_COUNT),
    .LINE_WIDTH   (LINE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (s_axis_tuser),
    .address_i     (s_axis_tdata[12:0]),
    .data_i        (s_axis_tdata[20:13]),
    .line_i        (s_axis_tdata[28:21]),
    .column_i      (s_axis_tdata[36:29]),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .color_o       (color),
    .from_object_o (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b000000, color};

endmodule

`default_nettype wire
